>>> rtl/ivs_pkg.sv
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types and constants for the indexed vector store.
// ----------------------------------------------------------------------------
package ivs_pkg;

  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 9;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 3'd0,
    MODE_SET    = 3'd1,
    MODE_GET    = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_ERASE  = 3'd4,
    MODE_PUSH   = 3'd5,
    MODE_POP    = 3'd6,
    MODE_CLEAR  = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_ZERO,
    S_SHIFT,
    S_FIN
  } state_t;

  // Port strobes from the sequencer to the element RAM
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

>>> rtl/ivs_mem.sv
// ----------------------------------------------------------------------------
// ivs_mem
// Element RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ivs_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  ivs_pkg::mem_ctl_t           ctl,
  input  logic [AW-1:0]               waddr,
  input  logic [ivs_pkg::WORD_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [ivs_pkg::WORD_W-1:0]  rdata
);

  logic [ivs_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ivs_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ivs_ctrl.sv
// ----------------------------------------------------------------------------
// ivs_ctrl
// Request decode, range checks, element count and the sequencer that walks
// the RAM for allocate, insert and erase.
// ----------------------------------------------------------------------------
module ivs_ctrl #(
  parameter int CAPACITY = 256,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ivs_pkg::MODE_W-1:0]    in_mode,
  input  logic [ivs_pkg::INDEX_W-1:0]   in_index,
  input  logic [ivs_pkg::WORD_W-1:0]    in_value,
  output logic                          out_valid,
  output logic [ivs_pkg::WORD_W-1:0]    out_read_value,
  output logic [ivs_pkg::STATUS_W-1:0]  out_status,
  output logic [ivs_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_empty_flag,
  output ivs_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 mem_waddr,
  output logic [ivs_pkg::WORD_W-1:0]    mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [ivs_pkg::WORD_W-1:0]    mem_rdata
);

  // common compare width for index, count and capacity
  localparam int WW = (CW > ivs_pkg::INDEX_W) ? CW : ivs_pkg::INDEX_W;

  ivs_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    newcnt_r, newcnt_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             have_r, have_nxt;
  logic             up_r, up_nxt;
  logic [ivs_pkg::WORD_W-1:0]   val_r, val_nxt;
  logic             vld_r, vld_nxt;
  logic [ivs_pkg::WORD_W-1:0]   rdv_r, rdv_nxt;
  ivs_pkg::status_t sts_r, sts_nxt;

  logic [WW-1:0]    idx_w, cnt_w, cap_w, idx_p1, cnt_m1_w;
  logic [CW-1:0]    cnt_m1;
  ivs_pkg::mode_t   mode;

  assign mode     = ivs_pkg::mode_t'(in_mode);
  assign idx_w    = WW'(in_index);
  assign cnt_w    = WW'(cnt_r);
  assign cap_w    = WW'(CAPACITY);
  assign idx_p1   = idx_w + WW'(1);
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m1_w = WW'(cnt_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ivs_pkg::S_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newcnt_r <= newcnt_nxt;
    rem_r    <= rem_nxt;
    ptr_r    <= ptr_nxt;
    wa_r     <= wa_nxt;
    idx_r    <= idx_nxt;
    up_r     <= up_nxt;
    val_r    <= val_nxt;
    rdv_r    <= rdv_nxt;
    sts_r    <= sts_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    newcnt_nxt = newcnt_r;
    rem_nxt    = rem_r;
    ptr_nxt    = ptr_r;
    wa_nxt     = wa_r;
    idx_nxt    = idx_r;
    have_nxt   = have_r;
    up_nxt     = up_r;
    val_nxt    = val_r;
    vld_nxt    = 1'b0;
    rdv_nxt    = rdv_r;
    sts_nxt    = sts_r;
    mem_ctl    = '0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;

    unique case (state_r)
      ivs_pkg::S_IDLE: begin
        if (start) begin
          // most modes finish right here; the result shows next cycle
          vld_nxt  = 1'b1;
          rdv_nxt  = '0;
          sts_nxt  = ivs_pkg::ST_OK;
          have_nxt = 1'b0;
          unique case (mode)
            ivs_pkg::MODE_ALLOC: begin
              if (idx_w > cap_w) begin
                sts_nxt = ivs_pkg::ST_RANGE;
              end else if (idx_w == '0) begin
                cnt_nxt = '0;
              end else begin
                vld_nxt    = 1'b0;
                newcnt_nxt = idx_w[CW-1:0];
                rem_nxt    = idx_w[CW-1:0];
                ptr_nxt    = '0;
                state_nxt  = ivs_pkg::S_ZERO;
              end
            end
            ivs_pkg::MODE_SET: begin
              if (idx_w >= cnt_w) begin
                sts_nxt = ivs_pkg::ST_RANGE;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = idx_w[AW-1:0];
                mem_wdata     = in_value;
              end
            end
            ivs_pkg::MODE_GET: begin
              if (idx_w >= cnt_w) begin
                sts_nxt = ivs_pkg::ST_RANGE;
              end else begin
                vld_nxt       = 1'b0;
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = idx_w[AW-1:0];
                state_nxt     = ivs_pkg::S_GET;
              end
            end
            ivs_pkg::MODE_INSERT: begin
              if (idx_w > cnt_w) begin
                sts_nxt = ivs_pkg::ST_RANGE;
              end else if (cnt_w >= cap_w) begin
                sts_nxt = ivs_pkg::ST_FULL;
              end else if (idx_w == cnt_w) begin
                // append, nothing to move
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = cnt_r[AW-1:0];
                mem_wdata     = in_value;
                cnt_nxt       = cnt_r + CW'(1);
              end else begin
                vld_nxt    = 1'b0;
                up_nxt     = 1'b1;
                ptr_nxt    = cnt_m1[AW-1:0];
                rem_nxt    = CW'(cnt_w - idx_w);
                idx_nxt    = idx_w[AW-1:0];
                val_nxt    = in_value;
                newcnt_nxt = cnt_r + CW'(1);
                state_nxt  = ivs_pkg::S_SHIFT;
              end
            end
            ivs_pkg::MODE_ERASE: begin
              if (idx_w >= cnt_w) begin
                sts_nxt = ivs_pkg::ST_RANGE;
              end else if (idx_w == cnt_m1_w) begin
                cnt_nxt = cnt_m1;
              end else begin
                vld_nxt    = 1'b0;
                up_nxt     = 1'b0;
                ptr_nxt    = idx_p1[AW-1:0];
                rem_nxt    = CW'(cnt_m1_w - idx_w);
                newcnt_nxt = cnt_m1;
                state_nxt  = ivs_pkg::S_SHIFT;
              end
            end
            ivs_pkg::MODE_PUSH: begin
              if (cnt_w >= cap_w) begin
                sts_nxt = ivs_pkg::ST_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = cnt_r[AW-1:0];
                mem_wdata     = in_value;
                cnt_nxt       = cnt_r + CW'(1);
              end
            end
            ivs_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                sts_nxt = ivs_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            ivs_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end

      ivs_pkg::S_GET: begin
        vld_nxt   = 1'b1;
        rdv_nxt   = mem_rdata;
        sts_nxt   = ivs_pkg::ST_OK;
        state_nxt = ivs_pkg::S_IDLE;
      end

      ivs_pkg::S_ZERO: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = ptr_r;
        mem_wdata     = '0;
        ptr_nxt       = ptr_r + AW'(1);
        rem_nxt       = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          cnt_nxt   = newcnt_r;
          vld_nxt   = 1'b1;
          state_nxt = ivs_pkg::S_IDLE;
        end
      end

      ivs_pkg::S_SHIFT: begin
        // read one entry ahead, write the word read last cycle one place over
        if (have_r) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = wa_r;
          mem_wdata     = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = ptr_r;
          wa_nxt        = up_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
          ptr_nxt       = up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
          rem_nxt       = rem_r - CW'(1);
          have_nxt      = 1'b1;
        end else begin
          have_nxt = 1'b0;
          if (up_r) begin
            state_nxt = ivs_pkg::S_FIN;
          end else begin
            cnt_nxt   = newcnt_r;
            vld_nxt   = 1'b1;
            state_nxt = ivs_pkg::S_IDLE;
          end
        end
      end

      ivs_pkg::S_FIN: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = idx_r;
        mem_wdata     = val_r;
        cnt_nxt       = newcnt_r;
        vld_nxt       = 1'b1;
        state_nxt     = ivs_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ivs_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != ivs_pkg::S_IDLE);
  assign out_valid      = vld_r;
  assign out_read_value = rdv_r;
  assign out_status     = sts_r;
  assign out_count      = cnt_w[ivs_pkg::COUNT_W-1:0];
  assign out_empty_flag = (cnt_r == '0);

endmodule

>>> rtl/indexed_vector_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_vector_store_unit
// Bounded ordered array of 64-bit words with a live count: allocate, set,
// get, insert, erase, push_back, pop_back and clear.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Ports
//  request   start & !busy          in_mode, in_index, in_value
//  result    out_valid, one cycle   out_read_value, out_status, out_count,
//                                   out_empty_flag
//
//  Set, push_back, pop_back, clear, insert at the end, erase of the last entry
//  and any refused request finish in idle; busy stays low, strobe next cycle.
//  Get goes through S_GET. Allocate zeroes the new entries, and any other insert
//  or erase shifts the entries behind the index, paced by the single RAM
//  write port moving one word per cycle; busy is high meanwhile.
//  Reset clears the count and the sequencer; RAM contents are not cleared.
//  Results cannot be stalled; a new request may be taken during the strobe.
// ----------------------------------------------------------------------------
module indexed_vector_store_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ivs_pkg::MODE_W-1:0]    in_mode,
  input  logic [ivs_pkg::INDEX_W-1:0]   in_index,
  input  logic [ivs_pkg::WORD_W-1:0]    in_value,
  output logic                          out_valid,
  output logic [ivs_pkg::WORD_W-1:0]    out_read_value,
  output logic [ivs_pkg::STATUS_W-1:0]  out_status,
  output logic [ivs_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_empty_flag
);

  localparam int AW = $clog2(CAPACITY);

  ivs_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic [ivs_pkg::WORD_W-1:0] mem_wdata;
  logic [ivs_pkg::WORD_W-1:0] mem_rdata;

  ivs_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_empty_flag (out_empty_flag),
    .mem_ctl        (mem_ctl),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  ivs_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> rtl/ivs_checker.sv
// ----------------------------------------------------------------------------
// ivs_checker
// Port-level checks on the indexed vector store, bound to the top level.
// ----------------------------------------------------------------------------
module ivs_checker #(
  parameter int CAPACITY = 256
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [ivs_pkg::MODE_W-1:0]    in_mode,
  input logic                          out_valid,
  input logic [ivs_pkg::WORD_W-1:0]    out_read_value,
  input logic [ivs_pkg::STATUS_W-1:0]  out_status,
  input logic [ivs_pkg::COUNT_W-1:0]   out_count,
  input logic                          out_empty_flag
);

  logic accept;
  assign accept = start && !busy;

  // set, push, pop and clear answer on the very next cycle
  a_quick_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == ivs_pkg::MODE_SET || in_mode == ivs_pkg::MODE_PUSH ||
               in_mode == ivs_pkg::MODE_POP || in_mode == ivs_pkg::MODE_CLEAR)
    |=> out_valid)
    else $error("single-cycle request gave no result beat");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == ivs_pkg::MODE_CLEAR
    |=> out_count == '0 && out_empty_flag && out_status == ivs_pkg::ST_OK)
    else $error("clear did not empty the array");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_empty_flag == (out_count == '0))
    else $error("empty flag disagrees with count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ivs_pkg::ST_OK |-> out_read_value == '0)
    else $error("refused request returned data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ivs_pkg::ST_FULL
    |-> out_count == ivs_pkg::COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

endmodule

bind indexed_vector_store_unit ivs_checker #(.CAPACITY(CAPACITY)) u_ivs_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for indexed_vector_store_unit. A short directed table
// covers the edges (empty and full array, bad indices, long shifts) and is
// followed by phases of random requests biased to grow, shrink or churn the
// array. A shadow copy of the store predicts every reply, and each strobed
// reply is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ivs_pkg::*;

  localparam int     CAPACITY   = 256;
  localparam int     RAND_ITEMS = 1300;
  localparam int     PHASE_LEN  = 100;
  localparam int     SETTLE     = CAPACITY + 40;
  localparam longint LIMIT      = 1_500_000;
  localparam int     MAX_PRINTS = 40;

  typedef struct packed {
    logic [WORD_W-1:0]  read_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty_flag;
  } vec_reply_t;

  typedef struct {
    mode_t              mode;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
    bit                 typed;
    vec_reply_t         reply;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [INDEX_W-1:0]  in_index = '0;
  logic [WORD_W-1:0]   in_value = '0;
  logic                out_valid;
  logic [WORD_W-1:0]   out_read_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty_flag;

  // shadow of the array, advanced as each request is taken
  logic [WORD_W-1:0] shadow_words [CAPACITY];
  int                shadow_count = 0;
  vec_reply_t        reply_q [$];
  stim_row_t         opening_rows [$];

  // per-phase mode weights in enum order, each row sums to 100:
  // alloc, set, get, insert, erase, push, pop, clear
  int mode_weight [24] = '{3, 12, 15, 25, 5, 35, 4, 1,    // grow
                           6, 10, 20, 7, 25, 10, 20, 2,   // shrink
                           9, 15, 17, 14, 14, 14, 12, 5}; // churn

  int     errors = 0;
  int     n_issued = 0;
  int     n_checked = 0;
  int     peak_count = 0;
  int     n_status [4] = '{0, 0, 0, 0};
  longint cycles = 0;

  indexed_vector_store_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_flag(out_empty_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, reply_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic vec_reply_t apply_request(mode_t m, int idx, logic [WORD_W-1:0] val);
    vec_reply_t r;
    int j;
    r.read_value = '0;
    r.status     = ST_OK;
    case (m)
      MODE_ALLOC: begin
        if (idx > CAPACITY) begin
          r.status = ST_RANGE;
        end else begin
          for (j = 0; j < idx; j++) shadow_words[j] = '0;
          shadow_count = idx;
        end
      end
      MODE_SET: begin
        if (idx >= shadow_count) r.status = ST_RANGE;
        else shadow_words[idx] = val;
      end
      MODE_GET: begin
        if (idx >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_words[idx];
      end
      MODE_INSERT: begin
        if (idx > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (j = shadow_count; j > idx; j--) shadow_words[j] = shadow_words[j-1];
          shadow_words[idx] = val;
          shadow_count++;
        end
      end
      MODE_ERASE: begin
        if (idx >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (j = idx; j + 1 < shadow_count; j++) shadow_words[j] = shadow_words[j+1];
          shadow_count--;
        end
      end
      MODE_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      MODE_POP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      default: shadow_count = 0;
    endcase
    r.count      = shadow_count[COUNT_W-1:0];
    r.empty_flag = (shadow_count == 0);
    return r;
  endfunction

  function automatic stim_row_t mk_row(mode_t m, int idx, logic [WORD_W-1:0] val, bit typed,
                                       status_t st, int cnt);
    stim_row_t row;
    row.mode             = m;
    row.index            = idx[INDEX_W-1:0];
    row.value            = val;
    row.typed            = typed;
    row.reply.read_value = '0;
    row.reply.status     = st;
    row.reply.count      = cnt[COUNT_W-1:0];
    row.reply.empty_flag = (cnt == 0);
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s (reply %0d): got %h, want %h",
               $time, what, n_checked, got, want);
  endtask

  // holds start until the beat is taken, then books the predicted reply
  task automatic issue(mode_t m, int idx, logic [WORD_W-1:0] val, bit typed,
                       vec_reply_t typed_reply);
    vec_reply_t r;
    start    <= 1'b1;
    in_mode  <= m;
    in_index <= idx[INDEX_W-1:0];
    in_value <= val;
    do @(posedge clk); while (busy);
    r = apply_request(m, idx, val);
    if (typed) r = typed_reply;
    reply_q.push_back(r);
    n_issued++;
    n_status[int'(r.status)]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    vec_reply_t want;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected reply, status", WORD_W'(out_status), '0);
      end else begin
        want = reply_q.pop_front();
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_status !== want.status)
          report_mismatch("status", WORD_W'(out_status), WORD_W'(want.status));
        if (out_count !== want.count)
          report_mismatch("count", WORD_W'(out_count), WORD_W'(want.count));
        if (out_empty_flag !== want.empty_flag)
          report_mismatch("empty_flag", WORD_W'(out_empty_flag), WORD_W'(want.empty_flag));
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    mode_t             m;
    int                idx;
    int                r;
    int                k;
    int                kind;
    bit                calm;
    logic [WORD_W-1:0] val;

    // empty-array refusals first, then edges at both ends of the store
    opening_rows.push_back(mk_row(MODE_GET, 0, '0, 1, ST_RANGE, 0));
    opening_rows.push_back(mk_row(MODE_POP, 0, '0, 1, ST_EMPTY, 0));
    opening_rows.push_back(mk_row(MODE_ERASE, 0, '0, 1, ST_RANGE, 0));
    opening_rows.push_back(mk_row(MODE_INSERT, 1, '1, 1, ST_RANGE, 0));
    opening_rows.push_back(mk_row(MODE_ALLOC, CAPACITY + 1, '0, 1, ST_RANGE, 0));
    opening_rows.push_back(mk_row(MODE_ALLOC, 511, '1, 1, ST_RANGE, 0));
    opening_rows.push_back(mk_row(MODE_PUSH, 0, '1, 1, ST_OK, 1));
    opening_rows.push_back(mk_row(MODE_INSERT, 0, '0, 1, ST_OK, 2));
    opening_rows.push_back(mk_row(MODE_INSERT, 2, {32{2'b10}}, 1, ST_OK, 3));
    opening_rows.push_back(mk_row(MODE_GET, 0, '1, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_SET, 2, {32{2'b01}}, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_GET, 2, '0, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_SET, 3, '1, 1, ST_RANGE, 3));
    opening_rows.push_back(mk_row(MODE_ERASE, 3, '0, 1, ST_RANGE, 3));
    opening_rows.push_back(mk_row(MODE_ERASE, 0, '0, 1, ST_OK, 2));
    opening_rows.push_back(mk_row(MODE_ALLOC, CAPACITY, '0, 1, ST_OK, CAPACITY));
    opening_rows.push_back(mk_row(MODE_PUSH, 0, '1, 1, ST_FULL, CAPACITY));
    opening_rows.push_back(mk_row(MODE_INSERT, CAPACITY, '1, 1, ST_FULL, CAPACITY));
    opening_rows.push_back(mk_row(MODE_SET, CAPACITY - 1, '1, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_ERASE, 0, '0, 1, ST_OK, CAPACITY - 1));
    opening_rows.push_back(mk_row(MODE_INSERT, 0, 64'h0123_4567_89ab_cdef, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_GET, CAPACITY - 1, '0, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_ALLOC, 0, '0, 1, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_PUSH, 0, 64'h8000_0000_0000_0001, 0, ST_OK, 0));
    opening_rows.push_back(mk_row(MODE_CLEAR, 0, '0, 1, ST_OK, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      issue(opening_rows[i].mode, int'(opening_rows[i].index), opening_rows[i].value,
            opening_rows[i].typed, opening_rows[i].reply);
      idle($urandom_range(0, 8));
    end
    drain_replies();

    for (int p = 0; p < RAND_ITEMS / PHASE_LEN; p++) begin
      kind = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        val = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) begin
          // noise: any mode, any index
          m   = mode_t'($urandom_range(0, 7));
          idx = $urandom_range(0, 511);
        end else begin
          r = $urandom_range(0, 99);
          k = 0;
          while (r >= mode_weight[kind*8 + k]) begin
            r -= mode_weight[kind*8 + k];
            k++;
          end
          m = mode_t'(k);
          case (m)
            MODE_ALLOC: begin
              r = $urandom_range(0, 99);
              if (r < 85) idx = $urandom_range(0, 12);
              else if (r < 94) idx = $urandom_range(13, 64);
              else idx = $urandom_range(CAPACITY - 2, CAPACITY + 2);
            end
            MODE_SET, MODE_GET, MODE_ERASE: begin
              if (shadow_count == 0 || $urandom_range(0, 9) == 0) idx = shadow_count;
              else idx = $urandom_range(0, shadow_count - 1);
            end
            MODE_INSERT: idx = $urandom_range(0, shadow_count);
            default: idx = $urandom_range(0, 511);
          endcase
        end
        issue(m, idx, val, 1'b0, '0);
        if (!calm) idle($urandom_range(0, 8));
      end
      if ($urandom_range(0, 1) == 0) drain_replies();
    end

    drain_replies();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests, %0d replies checked, peak occupancy %0d of %0d",
             n_issued, n_checked, peak_count, CAPACITY);
    $display("reply status mix: ok %0d, out of range %0d, full %0d, empty %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
